// File: hw/rtl/lz78se_pkg.sv
// Shared types and constants of the LZ78 stream encoder.
// No dependencies; imported by every module of the encoder.
`default_nettype none
package lz78se_pkg;
	localparam int DictDepth = 4096;
	localparam int IdxW      = 12;
	localparam int CntW      = 13;
	localparam int ByteW     = 8;
	localparam logic [CntW-1:0] LimitReset = CntW'(255);
	localparam logic [CntW-1:0] IndexSpan  = CntW'(4096);

	typedef struct packed {
		logic             last;
		logic [ByteW-1:0] data;
	} item_t;

	typedef struct packed {
		logic [IdxW-1:0]  index;
		logic [ByteW-1:0] byte_val;
		logic             last;
	} token_t;

	typedef struct packed {
		logic            busy;
		logic [CntW-1:0] entry_count;
	} core_status_t;
endpackage
`default_nettype wire

// File: hw/rtl/lz78se_queue.sv
// Two-entry input queue between the stream port and the search engine.
// Depends on lz78se_pkg for the item type.
`default_nettype none
module lz78se_queue import lz78se_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  item_t push_item,
	output logic  full,
	input  wire   pop,
	output item_t pop_item,
	output logic  empty
);
	item_t      slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign full     = (fill_q == 2'd2);
	assign empty    = (fill_q == 2'd0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/lz78se_core.sv
// Search engine: dictionary memory, linear scan and token output register.
// Depends on lz78se_pkg for types and sizes.
`default_nettype none
module lz78se_core import lz78se_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire [CntW-1:0]   dict_limit,
	input  wire              item_avail,
	input  item_t            item,
	output logic             item_pop,
	output logic             tok_valid,
	input  wire              tok_ready,
	output token_t           tok,
	output core_status_t     status
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [IdxW+ByteW-1:0] dict_mem [DictDepth];
	logic [IdxW+ByteW-1:0] rdata_s1;
	logic [IdxW-1:0]       chk_idx_s1;
	logic                  chk_v_s1;
	logic [CntW-1:0]       rd_idx_q;
	logic [CntW-1:0]       entry_count_q;
	logic [IdxW-1:0]       prefix_q;
	logic [IdxW-1:0]       found_q;
	logic                  hit_q;
	item_t                 cur_q;
	token_t                tok_q;
	logic                  tok_valid_q;
	logic                  slot_free, finish, room, we;
	logic [CntW-1:0]       room_lim;
	logic                  chk_hit, chk_end;

	assign room_lim  = (dict_limit > IndexSpan) ? IndexSpan : dict_limit;
	assign room      = entry_count_q < room_lim;
	assign slot_free = !tok_valid_q || tok_ready;
	assign finish    = (state_q == S_DONE) && slot_free;
	assign we        = finish && !hit_q && room;
	assign item_pop  = (state_q == S_IDLE) && item_avail;
	assign chk_hit   = chk_v_s1 && (rdata_s1 == {prefix_q, cur_q.data});
	assign chk_end   = chk_v_s1 && (({1'b0, chk_idx_s1} + CntW'(1)) == entry_count_q);

	assign tok_valid = tok_valid_q;
	assign tok       = tok_q;
	assign status    = '{busy: (state_q != S_IDLE), entry_count: entry_count_q};

	always_ff @(posedge clk) begin
		if (we) begin
			dict_mem[entry_count_q[IdxW-1:0]] <= {prefix_q, cur_q.data};
		end
		rdata_s1 <= dict_mem[rd_idx_q[IdxW-1:0]];
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q[IdxW-1:0];
		if (item_pop) begin
			cur_q <= item;
		end
		if (state_q == S_SCAN && chk_hit) begin
			found_q <= chk_idx_s1;
		end
		if (finish) begin
			if (hit_q) begin
				tok_q <= '{index: found_q, byte_val: '0, last: 1'b1};
			end else begin
				tok_q <= '{index: prefix_q, byte_val: cur_q.data, last: cur_q.last};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rd_idx_q      <= CntW'(1);
			chk_v_s1      <= 1'b0;
			entry_count_q <= CntW'(1);
			prefix_q      <= '0;
			hit_q         <= 1'b0;
			tok_valid_q   <= 1'b0;
		end else begin
			if (finish && !(hit_q && !cur_q.last)) begin
				tok_valid_q <= 1'b1;
			end else if (tok_ready) begin
				tok_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					chk_v_s1 <= 1'b0;
					rd_idx_q <= CntW'(1);
					hit_q    <= 1'b0;
					if (item_avail) begin
						state_q <= (entry_count_q > CntW'(1)) ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					// One entry is read per cycle; its compare follows in the next cycle.
					chk_v_s1 <= rd_idx_q < entry_count_q;
					if (rd_idx_q < entry_count_q) begin
						rd_idx_q <= rd_idx_q + CntW'(1);
					end
					if (chk_hit) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (chk_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					chk_v_s1 <= 1'b0;
					if (slot_free) begin
						state_q <= S_IDLE;
						if (hit_q && !cur_q.last) begin
							prefix_q <= found_q;
						end else begin
							prefix_q <= '0;
							if (cur_q.last) begin
								entry_count_q <= CntW'(1);
							end else if (we) begin
								entry_count_q <= entry_count_q + CntW'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/lz78_stream_encoder_unit.sv
// Top level of the LZ78 stream encoder: input queue and search engine.
// Depends on lz78se_pkg, lz78se_queue and lz78se_core.
//
// Channel   Direction  Content
// s_axis    in         tdata: data_byte[7:0]; tlast: is_last
// m_axis    out        tdata: token_index[11:0], token_byte[19:12], zero pad; tlast: token_last
// cfg       in         cfg_we, cfg_wdata: dict_limit[12:0]
//
// The scan reads one dictionary entry per cycle from the dictionary memory and
// stops at the first hit.
// Two bytes may wait in the input queue while a byte is scanned.
// Reset leaves the dictionary empty and dict_limit at 255; no clearing pass.
// A stalled token output holds the engine at the end of the next byte it has scanned.
`default_nettype none
module lz78_stream_encoder_unit import lz78se_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // data_byte
	input  wire         s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,   // token_index, token_byte, pad
	output logic        m_axis_tlast,   // token_last
	input  wire         cfg_we,
	input  wire  [12:0] cfg_wdata       // dict_limit
);
	logic [CntW-1:0] dict_limit_q;
	logic            q_full, q_empty, q_pop;
	item_t           q_item;
	token_t          tok;
	core_status_t    status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_limit_q <= LimitReset;
		end else if (cfg_we) begin
			dict_limit_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = !q_full;

	lz78se_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.push_item ('{last: s_axis_tlast, data: s_axis_tdata}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_item),
		.empty     (q_empty)
	);

	lz78se_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.dict_limit (dict_limit_q),
		.item_avail (!q_empty),
		.item       (q_item),
		.item_pop   (q_pop),
		.tok_valid  (m_axis_tvalid),
		.tok_ready  (m_axis_tready),
		.tok        (tok),
		.status     (status)
	);

	assign m_axis_tdata = {4'b0000, tok.byte_val, tok.index};
	assign m_axis_tlast = tok.last;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(status.entry_count >= CntW'(1)) && (status.entry_count <= IndexSpan))
		else $error("entry count out of range");

	a_pickup: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && !status.busy) |=> status.busy)
		else $error("queued byte not taken by the engine");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!status.busy && !q_empty))
		else $error("queue popped while engine busy");
endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench of the LZ78 stream encoder: byte streams in, tokens out.
// Depends on lz78se_pkg and lz78_stream_encoder_unit; a scoreboard class predicts the tokens.
module testbench;
	import lz78se_pkg::*;

	class token_board;
		logic [IdxW-1:0]  entry_prefix [DictDepth];
		logic [ByteW-1:0] entry_byte [DictDepth];
		int unsigned      entry_total;
		logic [IdxW-1:0]  prefix_now;
		int unsigned      limit;
		token_t           expected_tokens [$];
		int unsigned      mismatches;
		int unsigned      tokens_seen;
		int unsigned      final_hits;

		function new();
			limit = 255;
			entry_total = 1;
			prefix_now = '0;
			mismatches = 0;
			tokens_seen = 0;
			final_hits = 0;
		endfunction

		function int unsigned pending();
			return expected_tokens.size();
		endfunction

		function void note_byte(logic [ByteW-1:0] b, logic last);
			int unsigned hit;
			int unsigned room;
			token_t tok;
			hit = 0;
			for (int unsigned i = 1; i < entry_total && i < DictDepth; i++) begin
				if (hit == 0 && entry_prefix[i] == prefix_now && entry_byte[i] == b)
					hit = i;
			end
			if (hit != 0) begin
				if (!last) begin
					prefix_now = IdxW'(hit);
					return;
				end
				tok.index = IdxW'(hit);
				tok.byte_val = '0;
				tok.last = 1'b1;
				expected_tokens = {expected_tokens, tok};
				final_hits++;
				entry_total = 1;
				prefix_now = '0;
				return;
			end
			tok.index = prefix_now;
			tok.byte_val = b;
			tok.last = last;
			expected_tokens = {expected_tokens, tok};
			room = limit;
			if (room > DictDepth) room = DictDepth;
			if (entry_total < room) begin
				entry_prefix[entry_total] = prefix_now;
				entry_byte[entry_total] = b;
				entry_total++;
			end
			prefix_now = '0;
			if (last) entry_total = 1;
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_token(logic [IdxW-1:0] idx, logic [ByteW-1:0] b, logic last);
			token_t want;
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected token (%0d, %02h, %0b)", idx, b, last));
				return;
			end
			want = expected_tokens.pop_front();
			if (idx !== want.index)
				report_mismatch($sformatf("token_index %0d, want %0d", idx, want.index));
			if (b !== want.byte_val)
				report_mismatch($sformatf("token_byte %02h, want %02h", b, want.byte_val));
			if (last !== want.last)
				report_mismatch($sformatf("token_last %0b, want %0b", last, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [12:0] cfg_wdata;

	token_board  board;
	bit          calm;
	int unsigned hold_request;
	int unsigned bytes_sent;
	int unsigned phases_run;

	lz78_stream_encoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#40000000;
		$display("Timeout");
		$display("Mismatches found");
		$finish;
	end

	// Token receiver: random back-pressure bursts, plus one long hold when requested.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_token(m_axis_tdata[11:0], m_axis_tdata[19:12], m_axis_tlast);
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task send_byte(logic [7:0] b, logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		board.note_byte(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task idle_input(int unsigned n);
		repeat (n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			s_axis_tlast <= 1'($urandom);
			@(negedge clk);
		end
	endtask

	task send_with_gaps(logic [7:0] b, logic last);
		if (!calm && $urandom_range(0, 5) == 0)
			idle_input($urandom_range(1, 17));
		send_byte(b, last);
	endtask

	// The dictionary limit is only changed once every token has been collected.
	task set_dict_limit(int unsigned lim);
		idle_input(1);
		while (board.pending() != 0) @(negedge clk);
		idle_input(20);
		cfg_we <= 1'b1;
		cfg_wdata <= 13'(lim);
		@(negedge clk);
		cfg_we <= 1'b0;
		board.limit = lim;
		phases_run++;
	endtask

	// Streams mostly draw from a narrow alphabet so that prefixes grow and match.
	task send_streams(int unsigned count, int unsigned max_len);
		int unsigned sent;
		int unsigned len;
		logic [7:0] base;
		logic [7:0] mask;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, max_len);
			if (sent + len > count) len = count - sent;
			base = 8'($urandom);
			case ($urandom_range(0, 3))
				0: mask = 8'h01;
				1: mask = 8'h03;
				2: mask = 8'h07;
				default: mask = 8'hFF;
			endcase
			for (int unsigned k = 0; k < len; k++)
				send_with_gaps(base ^ (8'($urandom) & mask), k == len - 1);
			sent += len;
		end
	endtask

	initial begin
		board = new();
		calm = 1'b0;
		hold_request = 0;
		bytes_sent = 0;
		phases_run = 1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset limit: single-byte streams, extreme bytes,
		// a stream ending on a hit and a stream whose match grows.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);

		// Smallest limit: a single entry fits, so a repeated byte hits only that entry.
		set_dict_limit(2);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b1);
		hold_request = 400;
		send_streams(150, 30);

		set_dict_limit(3);
		send_streams(150, 30);
		set_dict_limit(4096);
		send_streams(200, 60);
		set_dict_limit(16);
		send_streams(150, 40);
		set_dict_limit(1000);
		send_streams(300, 300);
		set_dict_limit(7);
		hold_request = 300;
		send_streams(150, 25);
		set_dict_limit(255);
		send_streams(150, 40);
		calm = 1'b1;
		set_dict_limit(4096);
		send_streams(150, 40);

		idle_input(1);
		while (board.pending() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("Sent %0d bytes over %0d dictionary limit settings.", bytes_sent, phases_run);
		$display("Checked %0d tokens, %0d of them ending a stream on a match.",
			board.tokens_seen, board.final_hits);
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/lz78se_pkg.sv
hw/rtl/lz78se_queue.sv
hw/rtl/lz78se_core.sv
hw/rtl/lz78_stream_encoder_unit.sv
verif/testbench.sv
